// File: design/ealu_pkg.sv
// Package with the shared types and codes of the eight-bit ALU with condition flags.
`default_nettype none

package ealu_pkg;

    // Operation selector codes.
    typedef enum logic [4:0] {
        FN_ADD    = 5'd0,
        FN_ADC    = 5'd1,
        FN_SUB    = 5'd2,
        FN_SBC    = 5'd3,
        FN_OR     = 5'd4,
        FN_AND    = 5'd5,
        FN_TCM    = 5'd6,
        FN_TM     = 5'd7,
        FN_CP     = 5'd8,
        FN_XOR    = 5'd9,
        FN_INC    = 5'd10,
        FN_DEC    = 5'd11,
        FN_COM    = 5'd12,
        FN_RL     = 5'd13,
        FN_RLC    = 5'd14,
        FN_RR     = 5'd15,
        FN_RRC    = 5'd16,
        FN_SRA    = 5'd17,
        FN_SWAP   = 5'd18,
        FN_CLR    = 5'd19,
        FN_RCF    = 5'd20,
        FN_SCF    = 5'd21,
        FN_CCF    = 5'd22,
        FN_CCTEST = 5'd23,
        FN_NOP    = 5'd24
    } t_func;

    // Condition codes (low three bits of the condition field).
    typedef enum logic [2:0] {
        CC_NEVER = 3'd0,
        CC_LT    = 3'd1,
        CC_LE    = 3'd2,
        CC_ULE   = 3'd3,
        CC_OV    = 3'd4,
        CC_MI    = 3'd5,
        CC_Z     = 3'd6,
        CC_ULT   = 3'd7
    } t_cond;

    // Bit positions inside the flags byte.
    localparam int FL_C = 0;
    localparam int FL_Z = 1;
    localparam int FL_S = 2;
    localparam int FL_V = 3;
    localparam int FL_D = 4;
    localparam int FL_H = 5;

    localparam int CC_INV = 3;

    localparam logic [7:0] INC_OVF = 8'h80;
    localparam logic [7:0] DEC_OVF = 8'h7F;

    typedef struct packed {
        logic [4:0] func;
        logic [7:0] operand_a;
        logic [7:0] operand_b;
        logic [5:0] flags_in;
        logic [3:0] cond_code;
    } t_alu_in;

    typedef struct packed {
        logic [7:0] result;
        logic       writes_result;
        logic       cond_true;
        logic [5:0] flags_out;
    } t_alu_res;

endpackage

`default_nettype wire

// File: design/ealu_alu.sv
// Combinational datapath: byte operation, flag update and condition test.
`default_nettype none

module ealu_alu
    import ealu_pkg::*;
(
    input  t_alu_in  i_op,
    output t_alu_res o_res
);

    logic [7:0] a, b, r;
    logic [5:0] f, nf;
    logic       wr, cin, ci, cout, t;
    logic [8:0] sum9, diff9;
    logic [4:0] half5, hdiff5;

    assign a   = i_op.operand_a;
    assign b   = i_op.operand_b;
    assign f   = i_op.flags_in;
    assign cin = f[FL_C];

    // Carry-in for add with carry, borrow-in for subtract with borrow.
    always_comb begin
        ci = 1'b0;
        if (i_op.func == FN_ADC || i_op.func == FN_SBC) begin
            ci = cin;
        end
    end

    assign sum9   = {1'b0, a} + {1'b0, b} + {8'd0, ci};
    assign half5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};
    assign diff9  = {1'b0, a} - {1'b0, b} - {8'd0, ci};
    assign hdiff5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci};

    always_comb begin
        r    = 8'd0;
        wr   = 1'b0;
        nf   = f;
        cout = 1'b0;
        unique case (t_func'(i_op.func))
            FN_ADD, FN_ADC: begin
                r  = sum9[7:0];
                wr = 1'b1;
                nf = 6'd0;
                nf[FL_C] = sum9[8];
                nf[FL_H] = half5[4];
                nf[FL_V] = (a[7] ^ r[7]) & (b[7] ^ r[7]);
                nf[FL_Z] = (r == 8'd0);
                nf[FL_S] = r[7];
            end
            FN_SUB, FN_SBC, FN_CP: begin
                r  = diff9[7:0];
                nf[FL_C] = diff9[8];
                nf[FL_V] = (a[7] ^ b[7]) & (a[7] ^ r[7]);
                nf[FL_Z] = (r == 8'd0);
                nf[FL_S] = r[7];
                // Compare leaves direction and half carry alone.
                if (i_op.func != FN_CP) begin
                    wr = 1'b1;
                    nf[FL_H] = hdiff5[4];
                    nf[FL_D] = 1'b1;
                end
            end
            FN_OR, FN_AND, FN_TCM, FN_TM, FN_XOR, FN_COM, FN_SWAP: begin
                unique case (t_func'(i_op.func))
                    FN_OR:   r = a | b;
                    FN_AND:  r = a & b;
                    FN_TCM:  r = ~a & b;
                    FN_TM:   r = a & b;
                    FN_XOR:  r = a ^ b;
                    FN_COM:  r = ~a;
                    default: r = {a[3:0], a[7:4]};
                endcase
                wr = !(i_op.func == FN_TCM || i_op.func == FN_TM);
                nf[FL_Z] = (r == 8'd0);
                nf[FL_S] = r[7];
                nf[FL_V] = 1'b0;
            end
            FN_INC, FN_DEC: begin
                wr = 1'b1;
                if (i_op.func == FN_INC) begin
                    r = a + 8'd1;
                    nf[FL_V] = (r == INC_OVF);
                end else begin
                    r = a - 8'd1;
                    nf[FL_V] = (r == DEC_OVF);
                end
                nf[FL_Z] = (r == 8'd0);
                nf[FL_S] = r[7];
            end
            FN_RL, FN_RLC, FN_RR, FN_RRC, FN_SRA: begin
                wr = 1'b1;
                unique case (t_func'(i_op.func))
                    FN_RL:   begin r = {a[6:0], a[7]}; cout = a[7]; end
                    FN_RLC:  begin r = {a[6:0], cin};  cout = a[7]; end
                    FN_RR:   begin r = {a[0], a[7:1]}; cout = a[0]; end
                    FN_RRC:  begin r = {cin, a[7:1]};  cout = a[0]; end
                    default: begin r = {a[7], a[7:1]}; cout = a[0]; end
                endcase
                nf[FL_C] = cout;
                nf[FL_Z] = (r == 8'd0);
                nf[FL_S] = r[7];
                nf[FL_V] = 1'b0;
            end
            FN_CLR: begin
                wr = 1'b1;
            end
            FN_RCF: nf[FL_C] = 1'b0;
            FN_SCF: nf[FL_C] = 1'b1;
            FN_CCF: nf[FL_C] = ~cin;
            default: begin
                // Condition test, no-op and unused selectors keep everything.
            end
        endcase
    end

    always_comb begin
        unique case (t_cond'(i_op.cond_code[2:0]))
            CC_NEVER: t = 1'b0;
            CC_LT:    t = f[FL_S] ^ f[FL_V];
            CC_LE:    t = f[FL_Z] | (f[FL_S] ^ f[FL_V]);
            CC_ULE:   t = f[FL_C] | f[FL_Z];
            CC_OV:    t = f[FL_V];
            CC_MI:    t = f[FL_S];
            CC_Z:     t = f[FL_Z];
            default:  t = f[FL_C];
        endcase
    end

    assign o_res.result        = r;
    assign o_res.writes_result = wr;
    assign o_res.cond_true     = t ^ i_op.cond_code[CC_INV];
    assign o_res.flags_out     = nf;

endmodule

`default_nettype wire

// File: design/eight_bit_alu_flags_core.sv
// Top level of the eight-bit ALU with condition flags: input and result registers.
//
// Usage: drive the operation selector, both operand bytes, the current flags
// and a condition code, and raise start for one cycle. A transaction is taken
// at every rising edge where start is high and busy is low; busy never rises,
// so one transaction can be issued in every clock cycle.
// The operation is captured in an input register, computed by one pass of
// shallow byte logic, and caught in the result register. o_valid is loaded into
// the result stage from the input valid register and stays high for one cycle with
// the result byte, the write-back indication, the condition truth (tested
// on the incoming flags) and the new flags. Throughput is one transaction per
// cycle, set by the single registered datapath pass. The receiver cannot stall:
// each result is shown for exactly one cycle and must be taken then. A
// synchronous active-low reset drops all in-flight transactions and clears
// o_valid; payload registers are not reset.
`default_nettype none

module eight_bit_alu_flags_core
    import ealu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [4:0] i_func,
    input  wire logic [7:0] i_operand_a,
    input  wire logic [7:0] i_operand_b,
    input  wire logic [5:0] i_flags_in,
    input  wire logic [3:0] i_cond_code,
    output logic            o_valid,
    output logic [7:0]      o_result,
    output logic            o_writes_result,
    output logic            o_cond_true,
    output logic [5:0]      o_flags_out
);

    logic     r_in_vld, n_in_vld;
    t_alu_in  r_in, n_in;
    logic     r_out_vld, n_out_vld;
    t_alu_res r_out, n_out;

    assign busy      = 1'b0;
    assign n_in_vld  = start && !busy;
    assign n_in      = '{func: i_func, operand_a: i_operand_a, operand_b: i_operand_b,
                         flags_in: i_flags_in, cond_code: i_cond_code};
    assign n_out_vld = r_in_vld;

    ealu_alu u_alu (
        .i_op  (r_in),
        .o_res (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_in_vld) begin
            r_in <= n_in;
        end
        if (n_out_vld) begin
            r_out <= n_out;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_result        = r_out.result;
    assign o_writes_result = r_out.writes_result;
    assign o_cond_true     = r_out.cond_true;
    assign o_flags_out     = r_out.flags_out;

`ifndef NO_ASSERTIONS
    a_accept_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("accepted transaction did not produce a result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |=> !o_valid)
        else $error("result strobe without a transaction in flight");

    a_clr_keeps_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_in.func == FN_CLR) |=>
        (o_result == 8'd0 && o_writes_result && o_flags_out == $past(r_in.flags_in)))
        else $error("clear altered flags or gave a nonzero result");

    a_cp_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_in.func == FN_CP) |=>
        (!o_writes_result && o_flags_out[FL_D] == $past(r_in.flags_in[FL_D])
         && o_flags_out[FL_H] == $past(r_in.flags_in[FL_H])))
        else $error("compare wrote back or changed direction or half carry");
`endif

endmodule

`default_nettype wire
